/* rtl/sit_pkg.sv */
// Shared constants, register codes and the divider step for the tile picking pipeline.
`default_nettype none

package sit_pkg;

  localparam int BLK_BITS     = 11;
  localparam int MAP_BITS     = 15;
  localparam int CFG_BITS     = 15;
  localparam int CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BLOCK_WIDTH  = 2'd0,
    REG_BLOCK_HEIGHT = 2'd1,
    REG_MAP_ROWS     = 2'd2
  } cfg_reg_e;

  localparam logic [BLK_BITS-1:0] RST_BLOCK_WIDTH  = 11'd32;
  localparam logic [BLK_BITS-1:0] RST_BLOCK_HEIGHT = 11'd16;
  localparam logic [MAP_BITS-1:0] RST_MAP_ROWS     = 15'd112;

  typedef struct packed {
    logic [BLK_BITS-1:0] rem;
    logic                qbit;
  } dstep_t;

  // One restoring division step: bring in the next dividend bit, subtract if it fits.
  function automatic dstep_t div_step(input logic [BLK_BITS-1:0] rem,
                                      input logic                din,
                                      input logic [BLK_BITS-1:0] dvs);
    logic [BLK_BITS:0] t;
    dstep_t            s;
    t = {rem, din};
    if (t >= {1'b0, dvs}) begin
      s.rem  = BLK_BITS'(t - {1'b0, dvs});
      s.qbit = 1'b1;
    end else begin
      s.rem  = t[BLK_BITS-1:0];
      s.qbit = 1'b0;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

/* rtl/screen_to_iso_tile_top.sv */
// Isometric tile picking: screen pixel in, tile coordinates out, fully pipelined.
//
// Usage: present pixel_x_i/pixel_y_i with pixel_valid_i; the pixel transfers when
// pixel_ready_o is also high. One tile result per pixel appears on tile_x_o/tile_y_o
// with tile_valid_o and transfers when tile_ready_i is high. Results keep input order.
// Throughput is one pixel per cycle while tile_ready_i is high. The two signed
// dividers (column and row) resolve two quotient bits per stage; the remaining stages
// form the dividend, restore signs, apply the quadrant step and build the line origins.
// Each stage holds its own valid bit and only stalls when the stage after it is full,
// so a stalled receiver fills bubbles first and pixel_ready_o stays high while any
// stage is empty. Nothing is dropped or repeated under back-pressure.
// Reset empties the pipeline and loads block_width 32, block_height 16, map_rows 112.
// Write configuration through cfg_we_i/cfg_addr_i/cfg_wdata_i only while the pipeline
// is empty; writes to an unknown index are ignored. A block size of zero acts as one.
`default_nettype none

module screen_to_iso_tile_top
  import sit_pkg::*;
#(
  parameter int PIXEL_BITS = 16,
  parameter int COORD_BITS = 16,
  parameter int ORIGIN_ROW = 15
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]      cfg_addr_i,
  input  logic [CFG_BITS-1:0]          cfg_wdata_i,
  input  logic                         pixel_valid_i,
  output logic                         pixel_ready_o,
  input  logic signed [PIXEL_BITS-1:0] pixel_x_i,
  input  logic signed [PIXEL_BITS-1:0] pixel_y_i,
  output logic                         tile_valid_o,
  input  logic                         tile_ready_i,
  output logic signed [COORD_BITS-1:0] tile_x_o,
  output logic signed [COORD_BITS-1:0] tile_y_o
);

  localparam int DW    = ((PIXEL_BITS > BLK_BITS) ? PIXEL_BITS : BLK_BITS) + 1;
  localparam int NDS   = (DW + 1) / 2;
  localparam int DWP   = NDS * 2;
  localparam int GW    = DW + 1;
  localparam int RS    = BLK_BITS + 1;
  localparam int CW    = BLK_BITS + 12;
  localparam int WB    = (GW > COORD_BITS) ? GW : COORD_BITS;
  localparam int WW    = ((WB > MAP_BITS + 1) ? WB : MAP_BITS + 1) + 3;

  localparam int S_SUM = 0;
  localparam int S_MAG = 1;
  localparam int S_DIV = 2;
  localparam int S_SGN = NDS + 2;
  localparam int S_ADJ = NDS + 3;
  localparam int S_SUB = NDS + 4;
  localparam int S_OUT = NDS + 5;
  localparam int NST   = NDS + 6;

  localparam logic signed [CW-1:0] OY_C = CW'(ORIGIN_ROW);
  localparam logic signed [WW-1:0] OY_W = WW'(ORIGIN_ROW);

  // Configuration registers
  logic [BLK_BITS-1:0] block_width_q, block_height_q;
  logic [MAP_BITS-1:0] map_rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_width_q  <= RST_BLOCK_WIDTH;
      block_height_q <= RST_BLOCK_HEIGHT;
      map_rows_q     <= RST_MAP_ROWS;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_BLOCK_WIDTH:  block_width_q  <= cfg_wdata_i[BLK_BITS-1:0];
        REG_BLOCK_HEIGHT: block_height_q <= cfg_wdata_i[BLK_BITS-1:0];
        REG_MAP_ROWS:     map_rows_q     <= cfg_wdata_i[MAP_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic [BLK_BITS-1:0] bw_eff, bh_eff;
  logic [BLK_BITS-2:0] hw, hh;

  always_comb begin
    bw_eff = (block_width_q == '0) ? BLK_BITS'(1) : block_width_q;
    bh_eff = (block_height_q == '0) ? BLK_BITS'(1) : block_height_q;
    hw     = bw_eff[BLK_BITS-1:1];
    hh     = bh_eff[BLK_BITS-1:1];
  end

  // Stage valid bits and advance chain
  logic [NST-1:0] valid_q;
  logic [NST-1:0] adv;

  always_comb begin
    adv[NST-1] = !valid_q[NST-1] || tile_ready_i;
    for (int s = NST - 2; s >= 0; s--) begin
      adv[s] = !valid_q[s] || adv[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) begin
        valid_q[0] <= pixel_valid_i;
      end
      for (int s = 1; s < NST; s++) begin
        if (adv[s]) begin
          valid_q[s] <= valid_q[s-1];
        end
      end
    end
  end

  assign pixel_ready_o = adv[S_SUM];

  // Offset by half a block
  logic signed [DW-1:0] nx_d, ny_d, nx_q, ny_q;

  always_comb begin
    nx_d = DW'(pixel_x_i) + $signed(DW'(hw));
    ny_d = DW'(pixel_y_i) + $signed(DW'(hh));
  end

  always_ff @(posedge clk_i) begin
    if (adv[S_SUM]) begin
      nx_q <= nx_d;
      ny_q <= ny_d;
    end
  end

  // Split into sign and magnitude
  logic [DW-1:0]  magx_d, magy_d;
  logic [DWP-1:0] magx_q, magy_q;
  logic           sgnx_q, sgny_q;

  always_comb begin
    magx_d = nx_q[DW-1] ? DW'(-nx_q) : DW'(nx_q);
    magy_d = ny_q[DW-1] ? DW'(-ny_q) : DW'(ny_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv[S_MAG]) begin
      magx_q <= DWP'(magx_d);
      magy_q <= DWP'(magy_d);
      sgnx_q <= nx_q[DW-1];
      sgny_q <= ny_q[DW-1];
    end
  end

  // Divider stages: two quotient bits each; quotient bits shift in as dividend bits leave
  logic [BLK_BITS-1:0] rx_q [NDS];
  logic [BLK_BITS-1:0] ry_q [NDS];
  logic [DWP-1:0]      ax_q [NDS];
  logic [DWP-1:0]      ay_q [NDS];
  logic                sx_q [NDS];
  logic                sy_q [NDS];

  for (genvar j = 0; j < NDS; j++) begin : g_div
    logic [BLK_BITS-1:0] rx_in, ry_in, rx_d, ry_d;
    logic [DWP-1:0]      ax_in, ay_in, ax_d, ay_d;
    logic                sx_in, sy_in;

    if (j == 0) begin : g_first
      assign rx_in = '0;
      assign ry_in = '0;
      assign ax_in = magx_q;
      assign ay_in = magy_q;
      assign sx_in = sgnx_q;
      assign sy_in = sgny_q;
    end else begin : g_next
      assign rx_in = rx_q[j-1];
      assign ry_in = ry_q[j-1];
      assign ax_in = ax_q[j-1];
      assign ay_in = ay_q[j-1];
      assign sx_in = sx_q[j-1];
      assign sy_in = sy_q[j-1];
    end

    always_comb begin
      dstep_t stx;
      dstep_t sty;
      rx_d = rx_in;
      ry_d = ry_in;
      ax_d = ax_in;
      ay_d = ay_in;
      for (int b = 0; b < 2; b++) begin
        stx  = div_step(rx_d, ax_d[DWP-1], bw_eff);
        sty  = div_step(ry_d, ay_d[DWP-1], bh_eff);
        rx_d = stx.rem;
        ry_d = sty.rem;
        ax_d = {ax_d[DWP-2:0], stx.qbit};
        ay_d = {ay_d[DWP-2:0], sty.qbit};
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[S_DIV+j]) begin
        rx_q[j] <= rx_d;
        ry_q[j] <= ry_d;
        ax_q[j] <= ax_d;
        ay_q[j] <= ay_d;
        sx_q[j] <= sx_in;
        sy_q[j] <= sy_in;
      end
    end
  end

  // Restore signs: quotient and remainder both truncate toward zero
  logic signed [GW-1:0] qx_u, qy_u, qx2_q, qy2_q;
  logic signed [RS-1:0] rx_u, ry_u, cx2_q, cy2_q;

  always_comb begin
    qx_u = $signed({1'b0, ax_q[NDS-1][DW-1:0]});
    qy_u = $signed({1'b0, ay_q[NDS-1][DW-1:0]});
    rx_u = $signed({1'b0, rx_q[NDS-1]});
    ry_u = $signed({1'b0, ry_q[NDS-1]});
  end

  always_ff @(posedge clk_i) begin
    if (adv[S_SGN]) begin
      qx2_q <= sx_q[NDS-1] ? -qx_u : qx_u;
      qy2_q <= sy_q[NDS-1] ? -qy_u : qy_u;
      cx2_q <= sx_q[NDS-1] ? -rx_u : rx_u;
      cy2_q <= sy_q[NDS-1] ? -ry_u : ry_u;
    end
  end

  // Quadrant step inside a corner-centred cell
  logic signed [GW-1:0] gx_d, gy_d, gx3_q, gy3_q;
  logic signed [CW-1:0] cxe, cye;
  logic                 corner, left, upper;

  always_comb begin
    cxe    = CW'(cx2_q);
    cye    = CW'(cy2_q);
    corner = (!qx2_q[0] && !qy2_q[0]) ||
             (qx2_q[0] && qy2_q[0] && !qx2_q[GW-1] && !qy2_q[GW-1]);
    left   = cxe < ((OY_C - cye) <<< 1);
    upper  = (cye <<< 1) > cxe;
    gx_d   = qx2_q;
    gy_d   = qy2_q;
    if (corner) begin
      if (upper) begin
        if (left) begin
          gx_d = qx2_q - GW'(1);
        end else begin
          gy_d = qy2_q + GW'(1);
        end
      end else begin
        if (left) begin
          gy_d = qy2_q - GW'(1);
        end else begin
          gx_d = qx2_q + GW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[S_ADJ]) begin
      gx3_q <= gx_d;
      gy3_q <= gy_d;
    end
  end

  // Offsets from the flat origin and the two diagonal sums
  logic signed [WW-1:0] a_d, b_d, a4_q, b4_q, t14_q, t24_q;

  always_comb begin
    a_d = WW'(gx3_q) - $signed(WW'(map_rows_q));
    b_d = WW'(gy3_q) - OY_W;
  end

  always_ff @(posedge clk_i) begin
    if (adv[S_SUB]) begin
      a4_q  <= a_d;
      b4_q  <= b_d;
      t14_q <= a_d - b_d;
      t24_q <= -a_d - b_d;
    end
  end

  // Halve toward zero and form the tile coordinates
  logic signed [WW-1:0]         t1r, t2r, h1, h2;
  logic signed [COORD_BITS-1:0] tile_x_q, tile_y_q;

  always_comb begin
    t1r = t14_q + $signed({{(WW-1){1'b0}}, t14_q[WW-1]});
    t2r = t24_q + $signed({{(WW-1){1'b0}}, t24_q[WW-1]});
    h1  = t1r >>> 1;
    h2  = t2r >>> 1;
  end

  always_ff @(posedge clk_i) begin
    if (adv[S_OUT]) begin
      tile_x_q <= COORD_BITS'(a4_q - h1);
      tile_y_q <= COORD_BITS'(b4_q + h2);
    end
  end

  assign tile_valid_o = valid_q[S_OUT];
  assign tile_x_o     = tile_x_q;
  assign tile_y_o     = tile_y_q;

  // An empty output stage must leave room for a new pixel
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tile_valid_o |-> pixel_ready_o)
    else $error("pixel_ready_o low with an empty output stage");

  // A transferred pixel must occupy the first stage
  a_accept_fills_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_valid_i && pixel_ready_o |=> valid_q[S_SUM])
    else $error("accepted pixel not held in the first stage");

  // The quadrant step moves the column or the row, never both
  a_single_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv[S_ADJ] && valid_q[S_SGN] |=> (gx3_q == $past(qx2_q)) || (gy3_q == $past(qy2_q)))
    else $error("quadrant step moved both column and row");

endmodule

`default_nettype wire

/* bench/tb_screen_to_iso_tile_top.sv */
// Self-checking testbench for the isometric tile picking pipeline.
`default_nettype none

module tb_screen_to_iso_tile_top
  import sit_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIXEL_BITS   = 16;
  localparam int COORD_BITS   = 16;
  localparam int ORIGIN_ROW   = 15;
  localparam int CLK_PERIOD   = 20;
  localparam int LIMIT_CYCLES = 300_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 200;

  // index with no register behind it; writes there must be ignored
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [PIXEL_BITS-1:0] x;
    logic signed [PIXEL_BITS-1:0] y;
  } pixel_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } tile_t;

  typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_BLOCKS} rx_mode_e;

  logic                         clk_i;
  logic                         rst_ni        = 1'b0;
  logic                         cfg_we_i      = 1'b0;
  logic [CFG_IDX_BITS-1:0]      cfg_addr_i    = '0;
  logic [CFG_BITS-1:0]          cfg_wdata_i   = '0;
  logic                         pixel_valid_i = 1'b0;
  logic                         pixel_ready_o;
  logic signed [PIXEL_BITS-1:0] pixel_x_i     = '0;
  logic signed [PIXEL_BITS-1:0] pixel_y_i     = '0;
  logic                         tile_valid_o;
  logic                         tile_ready_i  = 1'b0;
  logic signed [COORD_BITS-1:0] tile_x_o;
  logic signed [COORD_BITS-1:0] tile_y_o;

  // shadow copy of the configuration registers
  logic [BLK_BITS-1:0] cfg_block_w  = RST_BLOCK_WIDTH;
  logic [BLK_BITS-1:0] cfg_block_h  = RST_BLOCK_HEIGHT;
  logic [MAP_BITS-1:0] cfg_map_rows = RST_MAP_ROWS;

  pixel_t   pending_pixels[$];
  tile_t    expected_tiles[$];
  pixel_t   next_pixel;
  tile_t    want_tile;
  int       error_count = 0;
  int       burst_left  = 1;
  int       gap_left    = 0;
  int       rx_count    = 0;
  int       stall_left  = 0;
  rx_mode_e rx_mode     = RX_OPEN;

  screen_to_iso_tile_top #(
    .PIXEL_BITS(PIXEL_BITS),
    .COORD_BITS(COORD_BITS),
    .ORIGIN_ROW(ORIGIN_ROW)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pixel_valid_i(pixel_valid_i),
    .pixel_ready_o(pixel_ready_o),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .tile_valid_o (tile_valid_o),
    .tile_ready_i (tile_ready_i),
    .tile_x_o     (tile_x_o),
    .tile_y_o     (tile_y_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("tb_screen_to_iso_tile_top: errors");
    $finish;
  end

  task automatic flag_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // Grid cell, quadrant step inside corner-centred cells, then line origins.
  function automatic tile_t pick_tile(input pixel_t p);
    longint px, py, bw, bh, ox, oy, gx, gy, cx, cy, lx, ly;
    bit     left_half;
    tile_t  t;
    px = $signed(p.x);
    py = $signed(p.y);
    bw = (cfg_block_w == '0) ? 64'sd1 : longint'(cfg_block_w);
    bh = (cfg_block_h == '0) ? 64'sd1 : longint'(cfg_block_h);
    ox = longint'(cfg_map_rows);
    oy = ORIGIN_ROW;
    gx = (px + bw / 2) / bw;
    gy = (py + bh / 2) / bh;
    // negative odd cells fall through both tests since % keeps the sign
    if ((gx % 2 == 1 && gy % 2 == 1) || (gx % 2 == 0 && gy % 2 == 0)) begin
      cx = px - (bw * gx - bw / 2);
      cy = py - (bh * gy - bh / 2);
      left_half = cx < (oy - cy) * 2;
      if (cy * 2 > cx) begin
        if (left_half) gx--;
        else gy++;
      end else begin
        if (left_half) gy--;
        else gx++;
      end
    end
    lx = ox + ((gx - ox) - (gy - oy)) / 2;
    ly = oy - (-(gx - ox) - (gy - oy)) / 2;
    t.x = COORD_BITS'(gx - lx);
    t.y = COORD_BITS'(gy - ly);
    return t;
  endfunction

  // Sender: bursts of random length with random gaps; valid only drops after a transfer.
  always @(posedge clk_i) begin
    if (pixel_valid_i && pixel_ready_o) begin
      expected_tiles = {expected_tiles, pick_tile(pixel_t'{x: pixel_x_i, y: pixel_y_i})};
    end
    if (!pixel_valid_i || pixel_ready_o) begin
      if (gap_left > 0) begin
        gap_left--;
        pixel_valid_i <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        next_pixel = pending_pixels.pop_front();
        pixel_valid_i <= 1'b1;
        pixel_x_i     <= next_pixel.x;
        pixel_y_i     <= next_pixel.y;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 32);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        pixel_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: check each transfer, then pick the next ready from the current stall mode.
  always @(posedge clk_i) begin
    if (rst_ni && tile_valid_o && tile_ready_i) begin
      if (expected_tiles.size() == 0) begin
        flag_error($sformatf("unexpected tile (%0d,%0d)", tile_x_o, tile_y_o));
      end else begin
        want_tile = expected_tiles.pop_front();
        if (tile_x_o !== want_tile.x)
          flag_error($sformatf("tile_x %0d, want %0d", tile_x_o, want_tile.x));
        if (tile_y_o !== want_tile.y)
          flag_error($sformatf("tile_y %0d, want %0d", tile_y_o, want_tile.y));
      end
    end
    if (rx_count == 0) begin
      rx_mode  = rx_mode_e'($urandom_range(0, 3));
      rx_count = $urandom_range(20, 300);
    end
    rx_count--;
    case (rx_mode)
      RX_OPEN:   tile_ready_i <= 1'b1;
      RX_MOSTLY: tile_ready_i <= ($urandom_range(0, 3) != 0);
      RX_SPARSE: tile_ready_i <= ($urandom_range(0, 3) == 0);
      default: begin
        if (stall_left == 0) begin
          stall_left = $urandom_range(1, 20);
          tile_ready_i <= 1'b1;
        end else begin
          stall_left--;
          tile_ready_i <= 1'b0;
        end
      end
    endcase
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_BITS-1:0]     val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_BLOCK_WIDTH:  cfg_block_w  = val[BLK_BITS-1:0];
      REG_BLOCK_HEIGHT: cfg_block_h  = val[BLK_BITS-1:0];
      REG_MAP_ROWS:     cfg_map_rows = val[MAP_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_blocks(input int bw, input int bh, input int rows);
    write_reg(REG_BLOCK_WIDTH, CFG_BITS'(bw));
    write_reg(REG_BLOCK_HEIGHT, CFG_BITS'(bh));
    write_reg(REG_MAP_ROWS, CFG_BITS'(rows));
  endtask

  task automatic add_pixel(input int x, input int y);
    pixel_t p;
    p.x = PIXEL_BITS'(x);
    p.y = PIXEL_BITS'(y);
    pending_pixels = {pending_pixels, p};
  endtask

  // Half full range, some within a few cells of the origin, some at the edges.
  task automatic add_random(input int count);
    int bw, bh, sel;
    for (int i = 0; i < count; i++) begin
      bw  = (cfg_block_w == '0) ? 1 : int'(cfg_block_w);
      bh  = (cfg_block_h == '0) ? 1 : int'(cfg_block_h);
      sel = $urandom_range(0, 9);
      if (sel < 5)
        add_pixel($urandom, $urandom);
      else if (sel < 8)
        add_pixel(int'($urandom_range(0, 8 * bw)) - 4 * bw,
                  int'($urandom_range(0, 8 * bh)) - 4 * bh);
      else
        add_pixel($urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 3 * bw))
                                       : -32768 + int'($urandom_range(0, 3 * bw)),
                  $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 3 * bh))
                                       : -32768 + int'($urandom_range(0, 3 * bh)));
    end
  endtask

  // Hold until every pixel has transferred and every tile has come back.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_pixels.size() != 0 || pixel_valid_i || expected_tiles.size() != 0);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset configuration: field extremes, quadrants, negative odd cells
    add_pixel(0, 0);
    add_pixel(-1, -1);
    add_pixel(32767, 32767);
    add_pixel(-32768, -32768);
    add_pixel(32767, -32768);
    add_pixel(-32768, 32767);
    add_pixel(16'h5555, 16'h2aaa);
    add_pixel(-21846, -10923);
    add_pixel(16, 8);
    add_pixel(-16, -8);
    add_pixel(-15, -7);
    add_pixel(15, -7);
    add_pixel(-15, 7);
    add_pixel(15, 7);
    add_pixel(-48, -24);
    add_pixel(-48, 24);
    add_pixel(48, -24);
    add_pixel(-80, -40);
    add_pixel(47, 23);
    add_pixel(-17, -9);
    add_pixel(31, 15);
    add_random(PHASE_ITEMS);
    wait_drained();

    // ignored index first, then the smallest blocks and origin column zero
    write_reg(REG_UNUSED, CFG_BITS'($urandom));
    set_blocks(1, 1, 0);
    add_random(PHASE_ITEMS);
    wait_drained();

    set_blocks(1024, 1024, 32767);
    add_pixel(32767, 32767);
    add_pixel(-32768, -32768);
    add_pixel(511, -512);
    add_pixel(-513, 512);
    add_random(PHASE_ITEMS);
    wait_drained();

    // zero block sizes act as one
    set_blocks(0, 0, $urandom_range(0, 32767));
    add_random(PHASE_ITEMS);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      set_blocks($urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(1, 1024),
                 $urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(1, 1024),
                 $urandom_range(0, 32767));
      add_random(PHASE_ITEMS);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) $display("tb_screen_to_iso_tile_top: clean");
    else $display("tb_screen_to_iso_tile_top: errors");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
rtl/sit_pkg.sv
rtl/screen_to_iso_tile_top.sv
bench/tb_screen_to_iso_tile_top.sv
